>>> design/stft_pkg.sv
// ----------------------------------------------------------------------------
// stft_pkg: shared constants, types and table functions
// Field widths of the spectrogram channels and the elaboration-time functions
// that build the window and twiddle tables.
// ----------------------------------------------------------------------------
package stft_pkg;

   localparam int FRAME_DEFAULT = 64;
   localparam int SAMPLE_W      = 16;
   localparam int BIN_W         = 6;
   localparam int MAG_W         = 16;
   localparam int FIDX_W        = 16;
   localparam int HOP_W         = 7;
   localparam int CPX_W         = 24;

   localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;
   localparam logic [63:0]      PI_Q30    = 64'd3373259426;
   localparam logic [63:0]      ONE_Q30   = 64'd1073741824;
   localparam logic [63:0]      HALF_Q30  = 64'd536870912;

   // One transform buffer entry: real part above imaginary part
   typedef struct packed {
      logic signed [CPX_W-1:0] re;
      logic signed [CPX_W-1:0] im;
   } cplx_type;

   // Shift-subtract long division, quotient
   function automatic logic [63:0] uquo(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Shift-subtract long division, remainder
   function automatic logic [63:0] urem(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] r;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) r = r - d;
      end
      return r;
   endfunction

   // cos(2*pi*num/den) in Q30 by a Taylor series after quadrant reduction
   function automatic longint cos_q30(input int unsigned num, input int unsigned den);
      logic [63:0] p;
      logic [63:0] t;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] dd;
      logic [1:0]  q;
      longint      sum;
      p    = urem(64'(num), 64'(den));
      t    = uquo(p << 32, 64'(den));
      q    = t[31:30];
      r    = t & 64'h3FFF_FFFF;
      if (q[0]) r = ONE_Q30 - r;
      x    = (r * PI_Q30 + ONE_Q30) >> 31;
      x2   = (x * x + HALF_Q30) >> 30;
      term = ONE_Q30;
      sum  = longint'(ONE_Q30);
      for (int k = 1; k <= 8; k++) begin
         dd   = 64'((2 * k - 1) * (2 * k));
         term = (term * x2 + HALF_Q30) >> 30;
         term = uquo(term + (dd >> 1), dd);
         if ((k & 1) != 0) sum = sum - longint'(term);
         else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      return (q == 2'd1 || q == 2'd2) ? -sum : sum;
   endfunction

   // Hann window entry in Q1.15, 0..32768
   function automatic logic [16:0] win_val(input int unsigned i, input int unsigned frame);
      longint c;
      longint v;
      c = cos_q30(i, frame - 1);
      v = (longint'(ONE_Q30) - c + 32768) >>> 16;
      return v[16:0];
   endfunction

   // Rounded and saturated Q15 cosine
   function automatic logic signed [15:0] cos_q15(input int unsigned num,
                                                  input int unsigned den);
      longint v;
      v = (cos_q30(num, den) + 16384) >>> 15;
      if (v > 32767)  v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

endpackage

>>> design/stft_if.sv
// ----------------------------------------------------------------------------
// stft_if: channel interfaces
// Sample request, bin response and configuration write channels.
// ----------------------------------------------------------------------------
interface stft_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [stft_pkg::SAMPLE_W-1:0] sample;
   logic                                 clip_start;

   modport source  (output valid, output sample, output clip_start, input ready);
   modport sink    (input valid, input sample, input clip_start, output ready);
   modport monitor (input valid, input sample, input clip_start, input ready);
endinterface

interface stft_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [stft_pkg::BIN_W-1:0]  bin_index;
   logic [stft_pkg::MAG_W-1:0]  magnitude;
   logic [stft_pkg::FIDX_W-1:0] frame_index;
   logic                        last_bin;

   modport source  (output valid, output bin_index, output magnitude,
                    output frame_index, output last_bin, input ready);
   modport sink    (input valid, input bin_index, input magnitude,
                    input frame_index, input last_bin, output ready);
   modport monitor (input valid, input bin_index, input magnitude,
                    input frame_index, input last_bin, input ready);
endinterface

interface stft_csr_if;
   logic                       valid;
   logic                       ready;
   logic [stft_pkg::HOP_W-1:0] hop_size;

   modport source  (output valid, output hop_size, input ready);
   modport sink    (input valid, input hop_size, output ready);
   modport monitor (input valid, input hop_size, input ready);
endinterface

>>> design/stft_ram.sv
// ----------------------------------------------------------------------------
// stft_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle, read data in the following cycle.
// ----------------------------------------------------------------------------
module stft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/stft_magnitude_spectrogram.sv
// ----------------------------------------------------------------------------
// stft_magnitude_spectrogram: Hann-windowed STFT magnitude spectrogram
// Windowed radix-2 transform of the last FRAME samples, bin magnitudes out.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one Q15 sample per beat; clip_start on a beat restarts
//   frame counting for a new clip. csr_chan writes hop_size at any idle time.
//   rsp_chan returns FRAME/2+1 beats per completed frame, bins in order, with
//   last_bin on the final one.
// Timing:
//   A sample that completes no frame leaves the block idle for the next one. A
//   completing sample keeps req_chan stalled through the load of the FRAME
//   windowed samples, then the butterflies (one shared multiplier, one read
//   and one write port on the transform RAM), then the squares and a
//   bit-serial square root for each bin, plus the wait for rsp ready.
// Reset:
//   Synchronous; counters clear, hop_size returns to 16. RAM contents are not
//   cleared; a frame only reads ring entries written since its clip began.
// Stall:
//   Each bin is held in the response register until taken; the transform
//   pauses meanwhile.
// ----------------------------------------------------------------------------
module stft_magnitude_spectrogram #(
   parameter int FRAME = stft_pkg::FRAME_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   stft_req_if.sink   req_chan,
   stft_rsp_if.source rsp_chan,
   stft_csr_if.sink   csr_chan
);

   localparam int LOG   = $clog2(FRAME);
   localparam int IDX_W = LOG;
   localparam int BF_W  = LOG - 1;
   localparam int STG_W = $clog2(LOG);
   localparam int CNT_W = $clog2(FRAME + 1);
   localparam int K_W   = $clog2(FRAME / 2 + 1);
   localparam int HX_W  = (CNT_W > stft_pkg::HOP_W) ? CNT_W : stft_pkg::HOP_W;
   localparam int CW    = stft_pkg::CPX_W;
   localparam int PW    = 2 * CW;
   localparam int SQ_W  = PW + 1;
   localparam int IT_W  = 5;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_LDEND, ST_RA, ST_RB, ST_M0, ST_M1, ST_M2, ST_M3,
      ST_W0, ST_W1, ST_GRD, ST_GSQ0, ST_GSQ1, ST_ROOT, ST_OUT, ST_WAIT
   } state_type;

   state_type                   state_ff;
   logic [IDX_W-1:0]            wp_ff;
   logic [CNT_W-1:0]            fill_ff;
   logic [CNT_W-1:0]            hcnt_ff;
   logic [stft_pkg::FIDX_W-1:0] frame_ff;
   logic [stft_pkg::FIDX_W-1:0] fidx_ff;
   logic [stft_pkg::HOP_W-1:0]  hop_ff;
   logic [IDX_W-1:0]            ld_cnt_ff;
   logic                        ld_vld_ff;
   logic [IDX_W-1:0]            ld_idx_ff;
   logic [STG_W-1:0]            stg_ff;
   logic [BF_W-1:0]             bf_ff;
   stft_pkg::cplx_type          a_ff;
   stft_pkg::cplx_type          b_ff;
   logic signed [PW-1:0]        p_ff;
   logic signed [PW-1:0]        tr_ff;
   logic signed [PW-1:0]        ti_ff;
   logic [K_W-1:0]              k_ff;
   logic signed [CW-1:0]        im_ff;
   logic [PW-1:0]               sq_ff;
   logic [SQ_W-1:0]             rn_ff;
   logic [SQ_W-1:0]             res_ff;
   logic [SQ_W-1:0]             bit_ff;
   logic [IT_W-1:0]             it_ff;
   logic                        rsp_valid_ff;
   logic [stft_pkg::BIN_W-1:0]  rsp_bin_ff;
   logic [stft_pkg::MAG_W-1:0]  rsp_mag_ff;
   logic [stft_pkg::FIDX_W-1:0] rsp_fidx_ff;
   logic                        rsp_last_ff;

   // Constant tables
   logic [16:0]        win_rom [FRAME];
   logic signed [15:0] cos_rom [FRAME/2];
   logic signed [15:0] sin_rom [FRAME/2];

   for (genvar gi = 0; gi < FRAME; gi++) begin : g_win
      assign win_rom[gi] = stft_pkg::win_val(gi, FRAME);
   end
   for (genvar gt = 0; gt < FRAME / 2; gt++) begin : g_twd
      assign cos_rom[gt] = stft_pkg::cos_q15(gt, FRAME);
      assign sin_rom[gt] = stft_pkg::cos_q15(4 * gt + 3 * FRAME, 4 * FRAME);
   end

   // Handshakes
   logic req_beat;
   logic rsp_beat;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign rsp_beat       = rsp_chan.valid && rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bin_index   = rsp_bin_ff;
   assign rsp_chan.magnitude   = rsp_mag_ff;
   assign rsp_chan.frame_index = rsp_fidx_ff;
   assign rsp_chan.last_bin    = rsp_last_ff;

   // Frame completion decision for an accepted sample
   logic [CNT_W-1:0]            fill_base;
   logic [CNT_W-1:0]            hop_base;
   logic [stft_pkg::FIDX_W-1:0] frame_base;
   logic [CNT_W-1:0]            fill_inc;
   logic [CNT_W-1:0]            hc_inc;
   logic [HX_W-1:0]             hop_x;
   logic [HX_W-1:0]             hop_eff;
   logic [CNT_W-1:0]            fill_in;
   logic [CNT_W-1:0]            hcnt_in;
   logic                        fire;

   always_comb begin
      fill_base  = req_chan.clip_start ? '0 : fill_ff;
      hop_base   = req_chan.clip_start ? '0 : hcnt_ff;
      frame_base = req_chan.clip_start ? '0 : frame_ff;
      fill_inc   = fill_base + CNT_W'(1);
      hc_inc     = hop_base + CNT_W'(1);
      hop_x      = HX_W'(hop_ff);
      if (hop_x == '0)                  hop_eff = HX_W'(1);
      else if (hop_x > HX_W'(FRAME))    hop_eff = HX_W'(FRAME);
      else                              hop_eff = hop_x;
      if (fill_base < CNT_W'(FRAME)) begin
         fill_in = fill_inc;
         fire    = (fill_inc == CNT_W'(FRAME));
         hcnt_in = fire ? '0 : hop_base;
      end else begin
         fill_in = fill_base;
         fire    = (HX_W'(hc_inc) >= hop_eff);
         hcnt_in = fire ? '0 : hc_inc;
      end
   end

   // Sample ring
   logic [15:0] ring_rd;

   stft_ram #(.WIDTH(stft_pkg::SAMPLE_W), .DEPTH(FRAME)) u_ring (
      .clock   (clock),
      .wr_en   (req_beat),
      .wr_addr (wp_ff),
      .wr_data (req_chan.sample),
      .rd_addr (wp_ff + ld_cnt_ff),
      .rd_data (ring_rd)
   );

   // Window multiply and bit-reversed placement
   logic signed [33:0]  win_prod;
   logic signed [33:0]  win_rnd;
   logic [IDX_W-1:0]    ld_rev;

   always_comb begin
      win_prod = $signed(ring_rd) * $signed({1'b0, win_rom[ld_idx_ff]});
      win_rnd  = (win_prod + 34'sd16384) >>> 15;
      for (int b = 0; b < IDX_W; b++) ld_rev[b] = ld_idx_ff[IDX_W-1-b];
   end

   // Butterfly addressing
   logic [IDX_W-1:0] bf_x;
   logic [IDX_W-1:0] half;
   logic [IDX_W-1:0] jj;
   logic [IDX_W-1:0] grp;
   logic [IDX_W-1:0] addr_a;
   logic [IDX_W-1:0] addr_b;
   logic [IDX_W-1:0] wsh;
   logic [BF_W-1:0]  widx;

   always_comb begin
      bf_x   = IDX_W'(bf_ff);
      half   = IDX_W'(1) << stg_ff;
      jj     = bf_x & (half - IDX_W'(1));
      grp    = ((bf_x >> stg_ff) << 1) << stg_ff;
      addr_a = grp | jj;
      addr_b = addr_a | half;
      wsh    = jj << (STG_W'(LOG - 1) - stg_ff);
      widx   = wsh[BF_W-1:0];
   end

   // Shared multiplier
   stft_pkg::cplx_type   tb_rd;
   logic signed [CW-1:0] mul_a;
   logic signed [CW-1:0] mul_b;
   logic signed [PW-1:0] prod;

   always_comb begin
      mul_a = tb_rd.re;
      mul_b = CW'(cos_rom[widx]);
      case (state_ff)
         ST_M1:   begin mul_a = b_ff.im; mul_b = CW'(sin_rom[widx]); end
         ST_M2:   begin mul_a = b_ff.im; mul_b = CW'(cos_rom[widx]); end
         ST_M3:   begin mul_a = b_ff.re; mul_b = CW'(sin_rom[widx]); end
         ST_GSQ0: begin mul_a = tb_rd.re; mul_b = tb_rd.re; end
         ST_GSQ1: begin mul_a = im_ff; mul_b = im_ff; end
         default: begin mul_a = tb_rd.re; mul_b = CW'(cos_rom[widx]); end
      endcase
      prod = mul_a * mul_b;
   end

   // Butterfly outputs, rounded halving
   logic signed [PW-1:0] ar;
   logic signed [PW-1:0] ai;
   logic signed [PW-1:0] sum_ar;
   logic signed [PW-1:0] sum_ai;
   logic signed [PW-1:0] dif_br;
   logic signed [PW-1:0] dif_bi;
   stft_pkg::cplx_type   new_a;
   stft_pkg::cplx_type   new_b;
   stft_pkg::cplx_type   ld_word;

   always_comb begin
      ar       = PW'(a_ff.re) <<< 15;
      ai       = PW'(a_ff.im) <<< 15;
      sum_ar   = (ar + tr_ff + PW'(32768)) >>> 16;
      sum_ai   = (ai + ti_ff + PW'(32768)) >>> 16;
      dif_br   = (ar - tr_ff + PW'(32768)) >>> 16;
      dif_bi   = (ai - ti_ff + PW'(32768)) >>> 16;
      new_a.re = sum_ar[CW-1:0];
      new_a.im = sum_ai[CW-1:0];
      new_b.re = dif_br[CW-1:0];
      new_b.im = dif_bi[CW-1:0];
      ld_word.re = win_rnd[CW-1:0];
      ld_word.im = '0;
   end

   // Transform buffer port control; butterflies are serialized, so a read
   // never overlaps a pending write to the same entry
   logic                tb_we;
   logic [IDX_W-1:0]    tb_waddr;
   stft_pkg::cplx_type  tb_wdata;
   logic [IDX_W-1:0]    tb_raddr;

   always_comb begin
      tb_we    = ld_vld_ff || (state_ff == ST_W0) || (state_ff == ST_W1);
      tb_waddr = addr_b;
      tb_wdata = new_b;
      if (ld_vld_ff) begin
         tb_waddr = ld_rev;
         tb_wdata = ld_word;
      end else if (state_ff == ST_W0) begin
         tb_waddr = addr_a;
         tb_wdata = new_a;
      end
      case (state_ff)
         ST_RB:   tb_raddr = addr_b;
         ST_GRD:  tb_raddr = IDX_W'(k_ff);
         default: tb_raddr = addr_a;
      endcase
   end

   stft_ram #(.WIDTH(PW), .DEPTH(FRAME)) u_tbuf (
      .clock   (clock),
      .wr_en   (tb_we),
      .wr_addr (tb_waddr),
      .wr_data (tb_wdata),
      .rd_addr (tb_raddr),
      .rd_data (tb_rd)
   );

   // Square root step and final rounding
   logic [SQ_W-1:0]            trial;
   logic [SQ_W-1:0]            root_rnd;
   logic [stft_pkg::MAG_W-1:0] mag_sat;

   always_comb begin
      trial    = res_ff + bit_ff;
      root_rnd = (rn_ff > res_ff) ? res_ff + SQ_W'(1) : res_ff;
      mag_sat  = (root_rnd > SQ_W'(16'hFFFF)) ? 16'hFFFF : root_rnd[stft_pkg::MAG_W-1:0];
   end

   // Sequencer: accept, load, butterflies, magnitudes, delivery
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         hcnt_ff      <= '0;
         frame_ff     <= '0;
         hop_ff       <= stft_pkg::HOP_RESET;
         ld_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ld_vld_ff <= 1'b0;
         if (csr_chan.valid) hop_ff <= csr_chan.hop_size;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  wp_ff   <= wp_ff + IDX_W'(1);
                  fill_ff <= fill_in;
                  hcnt_ff <= hcnt_in;
                  if (fire) begin
                     fidx_ff   <= frame_base;
                     frame_ff  <= frame_base + 16'd1;
                     ld_cnt_ff <= '0;
                     stg_ff    <= '0;
                     bf_ff     <= '0;
                     state_ff  <= ST_LOAD;
                  end else begin
                     frame_ff  <= frame_base;
                  end
               end
            end
            ST_LOAD: begin
               ld_vld_ff <= 1'b1;
               ld_idx_ff <= ld_cnt_ff;
               ld_cnt_ff <= ld_cnt_ff + IDX_W'(1);
               if (ld_cnt_ff == IDX_W'(FRAME - 1)) state_ff <= ST_LDEND;
            end
            ST_LDEND: state_ff <= ST_RA;
            ST_RA:    state_ff <= ST_RB;
            ST_RB: begin
               a_ff     <= tb_rd;
               state_ff <= ST_M0;
            end
            ST_M0: begin
               b_ff     <= tb_rd;
               p_ff     <= prod;
               state_ff <= ST_M1;
            end
            ST_M1: begin
               tr_ff    <= p_ff + prod;
               state_ff <= ST_M2;
            end
            ST_M2: begin
               p_ff     <= prod;
               state_ff <= ST_M3;
            end
            ST_M3: begin
               ti_ff    <= p_ff - prod;
               state_ff <= ST_W0;
            end
            ST_W0: state_ff <= ST_W1;
            ST_W1: begin
               bf_ff <= bf_ff + BF_W'(1);
               if (bf_ff == BF_W'(FRAME / 2 - 1)) begin
                  if (stg_ff == STG_W'(LOG - 1)) begin
                     k_ff     <= '0;
                     state_ff <= ST_GRD;
                  end else begin
                     stg_ff   <= stg_ff + STG_W'(1);
                     state_ff <= ST_RA;
                  end
               end else begin
                  state_ff <= ST_RA;
               end
            end
            ST_GRD: state_ff <= ST_GSQ0;
            ST_GSQ0: begin
               im_ff    <= tb_rd.im;
               sq_ff    <= $unsigned(prod);
               state_ff <= ST_GSQ1;
            end
            ST_GSQ1: begin
               rn_ff    <= {1'b0, sq_ff} + {1'b0, $unsigned(prod)};
               res_ff   <= '0;
               bit_ff   <= SQ_W'(1) << (PW - 2);
               it_ff    <= '0;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (rn_ff >= trial) begin
                  rn_ff  <= rn_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               it_ff  <= it_ff + IT_W'(1);
               if (it_ff == IT_W'(PW / 2 - 1)) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_bin_ff   <= stft_pkg::BIN_W'(k_ff);
               rsp_mag_ff   <= mag_sat;
               rsp_fidx_ff  <= fidx_ff;
               rsp_last_ff  <= (k_ff == K_W'(FRAME / 2));
               state_ff     <= ST_WAIT;
            end
            ST_WAIT: begin
               if (rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (k_ff == K_W'(FRAME / 2)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + K_W'(1);
                     state_ff <= ST_GRD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Checks
   a_rsp_only_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_WAIT)
      else $error("response valid outside of delivery");

   a_last_on_top_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> k_ff == K_W'(FRAME / 2))
      else $error("last bin flag on wrong bin");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_chan.last_bin |=> state_ff == ST_IDLE)
      else $error("not idle after final bin");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      ld_vld_ff |-> !(state_ff == ST_W0 || state_ff == ST_W1))
      else $error("load and butterfly write collide");

endmodule

>>> tb/stft_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stft_tb_if: testbench view of the spectrogram channels
// The channel interfaces come from the design sources; this file only holds
// the beat record used by the checker.
// ----------------------------------------------------------------------------
package stft_tb_pkg;

   // One expected or observed bin beat
   typedef struct packed {
      logic [stft_pkg::BIN_W-1:0]  bin_index;
      logic [stft_pkg::MAG_W-1:0]  magnitude;
      logic [stft_pkg::FIDX_W-1:0] frame_index;
      logic                        last_bin;
   } bin_beat_type;
endpackage

>>> tb/stft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stft_checker: spectrogram predictor and bin scoreboard
// Watches the sample, configuration and bin channels, computes the windowed
// fixed-point transform for every completed frame and compares each bin beat
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module stft_checker #(
   parameter int FRAME = stft_pkg::FRAME_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   stft_req_if.monitor req_mon,
   stft_rsp_if.monitor rsp_mon,
   stft_csr_if.monitor csr_mon,
   output int          fail_count,
   output int          pending_bins,
   output int          bins_seen,
   output int          frames_seen
);

   localparam int LOG2F = $clog2(FRAME);

   logic signed [stft_pkg::SAMPLE_W-1:0] ring [FRAME];
   int unsigned                wr_ptr, fill, hop_cnt, frame_cnt, hop_reg;
   longint                     win  [FRAME];
   longint                     ctab [FRAME/2+1];
   longint                     stab [FRAME/2+1];
   stft_tb_pkg::bin_beat_type  expected_bins[$];

   // Round toward minus infinity after a right shift
   function automatic longint fshift(input longint v, input int s);
      return v >>> s;
   endfunction

   // Integer cosine, Q30, quadrant-reduced Taylor series
   function automatic longint cosine_q30(input longint unsigned num,
                                         input longint unsigned den);
      longint unsigned p, t, r, x, x2, term, d;
      int unsigned     q;
      longint          acc;
      p = num % den;
      t = (p << 32) / den;
      q = 32'((t >> 30) & 64'd3);
      r = t & 64'h3FFF_FFFF;
      if (q & 1) r = 64'h4000_0000 - r;
      x  = (r * 64'd3373259426 + 64'h4000_0000) >> 31;
      x2 = (x * x + 64'h2000_0000) >> 30;
      term = 64'd1073741824;
      acc  = 64'sd1073741824;
      for (int k = 1; k <= 8; k++) begin
         d = 64'((2 * k - 1) * (2 * k));
         term = (term * x2 + 64'h2000_0000) >> 30;
         term = (term + d / 2) / d;
         if (k & 1) acc -= longint'(term);
         else       acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > 1073741824) acc = 64'sd1073741824;
      return (q == 1 || q == 2) ? -acc : acc;
   endfunction

   function automatic longint cosine_q15(input longint unsigned num,
                                         input longint unsigned den);
      longint v;
      v = fshift(cosine_q30(num, den) + 16384, 15);
      if (v > 32767)  v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic longint unsigned round_sqrt(input longint unsigned v);
      longint unsigned res, bitv, n;
      res = 0;
      bitv = 64'd1 << 62;
      n = v;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      if (v > res * res + res) res++;
      return res;
   endfunction

   initial begin
      for (int i = 0; i < FRAME; i++)
         win[i] = (64'sd1073741824 - cosine_q30(i, FRAME - 1) + 32768) >>> 16;
      for (int i = 0; i <= FRAME / 2; i++) begin
         ctab[i] = cosine_q15(i, FRAME);
         stab[i] = cosine_q15(4 * i + 3 * FRAME, 4 * FRAME);
      end
   end

   // Window the ring, run the scaled radix-2 transform, queue bin beats
   task automatic predict_frame();
      longint    bre [FRAME];
      longint    bim [FRAME];
      longint    xw, tr, ti, ar, ai, c, s, re, im;
      int        rev, v, half, stp, w;
      longint unsigned m;
      stft_tb_pkg::bin_beat_type b;
      for (int i = 0; i < FRAME; i++) begin
         xw = fshift(longint'(ring[(wr_ptr + i) % FRAME]) * win[i] + 16384, 15);
         v = i;
         rev = 0;
         for (int k = 0; k < LOG2F; k++) begin
            rev = (rev << 1) | (v & 1);
            v >>= 1;
         end
         bre[rev] = xw;
         bim[rev] = 0;
      end
      for (int len = 2; len <= FRAME; len *= 2) begin
         half = len / 2;
         stp = FRAME / len;
         for (int st = 0; st < FRAME; st += len)
            for (int j = 0; j < half; j++) begin
               w = (j * stp) % (FRAME / 2 + 1);
               c = ctab[w];
               s = stab[w];
               tr = bre[st+j+half] * c + bim[st+j+half] * s;
               ti = bim[st+j+half] * c - bre[st+j+half] * s;
               ar = bre[st+j] * 32768;
               ai = bim[st+j] * 32768;
               bre[st+j]      = fshift(ar + tr + 32768, 16);
               bim[st+j]      = fshift(ai + ti + 32768, 16);
               bre[st+j+half] = fshift(ar - tr + 32768, 16);
               bim[st+j+half] = fshift(ai - ti + 32768, 16);
            end
      end
      for (int k = 0; k <= FRAME / 2; k++) begin
         re = bre[k];
         im = bim[k];
         m = round_sqrt(longint'(re * re) + longint'(im * im));
         if (m > 65535) m = 65535;
         b.bin_index   = k[stft_pkg::BIN_W-1:0];
         b.magnitude   = m[stft_pkg::MAG_W-1:0];
         b.frame_index = frame_cnt[stft_pkg::FIDX_W-1:0];
         b.last_bin    = (k == FRAME / 2);
         expected_bins.insert(expected_bins.size(), b);
      end
      frame_cnt = (frame_cnt + 1) & 16'hFFFF;
      frames_seen++;
   endtask

   // Advance the framing state by one accepted sample
   task automatic take_sample(input logic signed [stft_pkg::SAMPLE_W-1:0] smp,
                              input logic clip);
      int unsigned hop;
      bit          fire;
      hop = hop_reg;
      fire = 0;
      if (hop < 1) hop = 1;
      if (hop > FRAME) hop = FRAME;
      if (clip) begin
         fill = 0;
         hop_cnt = 0;
         frame_cnt = 0;
      end
      ring[wr_ptr] = smp;
      wr_ptr = (wr_ptr + 1) % FRAME;
      if (fill < FRAME) begin
         fill++;
         if (fill == FRAME) begin
            fire = 1;
            hop_cnt = 0;
         end
      end else begin
         hop_cnt++;
         if (hop_cnt >= hop) begin
            fire = 1;
            hop_cnt = 0;
         end
      end
      if (fire) predict_frame();
   endtask

   // Sample all channels at the edge and score the bin beats
   always @(posedge clock) begin
      stft_tb_pkg::bin_beat_type got, want;
      if (reset) begin
         wr_ptr = 0;
         fill = 0;
         hop_cnt = 0;
         frame_cnt = 0;
         hop_reg = 32'(stft_pkg::HOP_RESET);
         fail_count = 0;
         bins_seen = 0;
         frames_seen = 0;
         expected_bins.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) hop_reg = 32'(csr_mon.hop_size);
         if (req_mon.valid && req_mon.ready)
            take_sample(req_mon.sample, req_mon.clip_start);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.bin_index, rsp_mon.magnitude, rsp_mon.frame_index,
                    rsp_mon.last_bin};
            bins_seen++;
            if (expected_bins.size() == 0) begin
               $display("%0t: unexpected bin beat %p", $time, got);
               fail_count++;
            end else begin
               want = expected_bins.pop_front();
               if (got != want) begin
                  $display("%0t: bin mismatch expected %p actual %p", $time, want, got);
                  fail_count++;
               end
            end
         end
      end
      pending_bins = expected_bins.size();
   end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: spectrogram stimulus and verdict
// Drives directed and random samples across several hop settings, with
// random idle cycles on both channels and one long response hold-off, and
// reports the checker's outcome.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FRAME     = stft_pkg::FRAME_DEFAULT;
   localparam int IDLE_CAP  = 200000;
   localparam int FRAME_LAT = 4000;

   logic clock;
   logic reset;
   int   fail_count, pending_bins, bins_seen, frames_seen;
   int   idle_cycles;
   int   items_sent;
   bit   calm;      // no idling on either side
   bit   hold_rsp;  // long receiver hold-off

   stft_req_if req_chan ();
   stft_rsp_if rsp_chan ();
   stft_csr_if csr_chan ();

   stft_magnitude_spectrogram #(.FRAME(FRAME)) dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   stft_checker #(.FRAME(FRAME)) spectrum_check (
      .clock(clock), .reset(reset),
      .req_mon(req_chan), .rsp_mon(rsp_chan), .csr_mon(csr_chan),
      .fail_count(fail_count), .pending_bins(pending_bins),
      .bins_seen(bins_seen), .frames_seen(frames_seen)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Response side: random stalls, one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else if (hold_rsp) rsp_chan.ready <= 0;
      else rsp_chan.ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
   end

   // Watchdog on cycles with no beat accepted anywhere
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_CAP) begin
         $display("watchdog: no progress for %0d cycles", IDLE_CAP);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offer one sample beat and hold it until accepted; drop valid only
   // while idling so that back-to-back beats keep it high
   task automatic send_sample(input logic signed [stft_pkg::SAMPLE_W-1:0] smp,
                              input logic clip);
      while (!calm && $urandom_range(99) < 36) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid      <= 1;
      req_chan.sample     <= smp;
      req_chan.clip_start <= clip;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   // Stop offering, let the block drain, then write hop_size
   task automatic write_hop(input logic [stft_pkg::HOP_W-1:0] hop);
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_bins != 0) @(posedge clock);
      repeat (FRAME_LAT) @(posedge clock);
      csr_chan.valid    <= 1;
      csr_chan.hop_size <= hop;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 0;
   endtask

   // A well-formed clip: clip start then random samples
   task automatic send_clip(input int n, input bit loud);
      logic signed [stft_pkg::SAMPLE_W-1:0] s;
      for (int i = 0; i < n; i++) begin
         s = loud ? ($urandom_range(1) ? 16'sh7FFF : 16'sh8000) : 16'($urandom);
         send_sample(s, i == 0);
      end
   endtask

   // Receiver stops for a long stretch while samples keep coming
   initial begin
      hold_rsp = 0;
      wait (frames_seen >= 3);
      hold_rsp = 1;
      repeat (6000) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin
      reset = 1;
      calm = 0;
      items_sent = 0;
      req_chan.valid = 0;
      req_chan.sample = 0;
      req_chan.clip_start = 0;
      csr_chan.valid = 0;
      csr_chan.hop_size = stft_pkg::HOP_RESET;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: stream before any clip start, extremes, early clip restart
      for (int i = 0; i < 4; i++) send_sample(16'sh7FFF, 0);
      for (int i = 0; i < 4; i++) send_sample(16'sh8000, 0);
      send_sample(0, 0);
      send_sample(16'sh0001, 0);
      send_sample(-16'sh0001, 0);
      send_sample(16'sh5555, 1);
      send_sample(16'shAAAA, 0);
      for (int i = 0; i < 12; i++) send_sample(16'($urandom), 0);

      // Full-scale square clip at the reset hop; the receiver holds off
      // on its third frame while samples keep coming
      send_clip(FRAME + 40, 1);

      // Hop zero acts as one: every sample completes a frame
      write_hop(7'd0);
      for (int i = 0; i < 4; i++) send_sample(16'($urandom), 0);

      // Hop above the frame length acts as the frame length
      write_hop(7'd127);
      for (int i = 0; i < FRAME + 2; i++) send_sample(16'($urandom), 0);

      // Hop lowered mid-frame: counter already past new hop
      write_hop(7'd40);
      for (int i = 0; i < 30; i++) send_sample(16'($urandom), 0);
      write_hop(7'd5);
      for (int i = 0; i < 12; i++) send_sample(16'($urandom), 0);

      // Calm stretch with a short hop
      calm = 1;
      write_hop(7'd1);
      for (int i = 0; i < 20; i++) send_sample(16'($urandom), 0);
      calm = 0;

      // Random clips across hop settings, some broken early by a new clip
      while (items_sent < 270) begin
         write_hop(7'($urandom_range(65, 1)));
         if ($urandom_range(3) == 0) send_clip(int'($urandom_range(FRAME - 1, 1)), 0);
         else send_clip(FRAME + int'($urandom_range(40)), $urandom_range(7) == 0);
      end

      // Drain
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_bins != 0) @(posedge clock);
      repeat (FRAME_LAT) @(posedge clock);
      $display("run: %0d samples, %0d frames, %0d bins checked across hop 0..127,",
               items_sent, frames_seen, bins_seen);
      $display("     clip restarts, full-scale input and a long receiver hold-off");
      if (fail_count == 0 && pending_bins == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> sim.f
design/stft_pkg.sv
design/stft_if.sv
design/stft_ram.sv
design/stft_magnitude_spectrogram.sv
tb/stft_tb_if.sv
tb/stft_checker.sv
tb/testbench.sv
